// File: rtl/cmw_pkg.sv
package cmw_pkg;

    // screen geometry
    localparam int COLUMNS = 160;
    localparam int ROWS    = 200;

    // offset word: sign bit plus room for 0..ROWS
    localparam int OFF_W = $clog2(ROWS + 1) + 1;
    // column index into the offset memory
    localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    // tick walk counter, must hold COLUMNS itself
    localparam int CNT_W = $clog2(COLUMNS + 1);
    // width for row minus offset arithmetic
    localparam int LK_W  = ((OFF_W > 8) ? OFF_W : 8) + 1;

    // melt rules
    localparam int FAST_LIMIT = 16;
    localparam int SLOW_STEP  = ROWS / 25;
    localparam int INIT_MIN   = -15;

    typedef enum logic [1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_LOOK
    } state_t;

endpackage

// File: rtl/cmw_advance_unit.sv
module cmw_advance_unit (
    input  logic signed [cmw_pkg::OFF_W-1:0] off,
    output logic signed [cmw_pkg::OFF_W-1:0] off_new,
    output logic                             moved
);

    localparam int XW = cmw_pkg::OFF_W + 1;
    localparam logic signed [XW-1:0] ROWS_X = XW'(cmw_pkg::ROWS);
    localparam logic signed [XW-1:0] FAST_X = XW'(cmw_pkg::FAST_LIMIT);
    localparam logic signed [XW-1:0] SLOW_X = XW'(cmw_pkg::SLOW_STEP);
    localparam logic signed [XW-1:0] ONE_X  = XW'(1);

    logic signed [XW-1:0] off_x;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] grown;

    always_comb
    begin
        off_x = XW'(off);
        dy    = (off_x < FAST_X) ? (off_x + ONE_X) : SLOW_X;
        grown = off_x + dy;
        if (off_x < 0)
        begin
            // still waiting to start falling
            off_new = cmw_pkg::OFF_W'(off_x + ONE_X);
            moved   = 1'b1;
        end
        else if (off_x < ROWS_X)
        begin
            off_new = (grown >= ROWS_X) ? cmw_pkg::OFF_W'(ROWS_X) : cmw_pkg::OFF_W'(grown);
            moved   = 1'b1;
        end
        else
        begin
            off_new = off;
            moved   = 1'b0;
        end
    end

endmodule

// File: rtl/column_melt_wipe_engine_unit.sv
// column melt screen wipe engine
//
// input channel (in_valid / in_stall) carries one item: func, random_value,
// column and row. func init loads the next column offset from the random
// byte, func tick advances every column once, func lookup names the screen
// and row that supply pixel (column, row). every item gives one result item
// on the output channel (out_valid / out_stall): done_res for a tick,
// from_new and source_row for a lookup, all zero otherwise.
//
// one item is handled at a time. for init, the result is in the output
// register after the accepting edge. lookup does one offset memory read,
// then the compare. tick issues the first read, then a single shared
// advance unit walks the offset memory, reading one column and writing
// back the previous one each cycle.
//
// in_stall is high while an item is in work, and while a result waits and
// out_stall is high. a stalled result holds in the output register.
// reset clears the sequencer, the output valid and the init chain offset;
// column offsets are undefined until an init writes them.
module column_melt_wipe_engine_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] random_value,
    input  logic [7:0] column,
    input  logic [7:0] row,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       done_res,
    output logic       from_new,
    output logic [7:0] source_row
);

    localparam int OFF_W = cmw_pkg::OFF_W;
    localparam int IDX_W = cmw_pkg::IDX_W;
    localparam int CNT_W = cmw_pkg::CNT_W;
    localparam int LK_W  = cmw_pkg::LK_W;
    localparam int SW    = OFF_W + 1;
    localparam logic signed [SW-1:0] INIT_MIN_X = SW'(cmw_pkg::INIT_MIN);
    localparam logic signed [SW-1:0] ONE_X      = SW'(1);

    cmw_pkg::state_t state_reg, state_next;

    // offset memory, registered read
    logic signed [OFF_W-1:0] mem [cmw_pkg::COLUMNS];
    logic signed [OFF_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    mem_we;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [OFF_W-1:0] wr_data;

    // tick walk
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             pend_reg, pend_next;
    logic             changed_reg, changed_next;

    // lookup context
    logic       look_ok_reg, look_ok_next;
    logic [7:0] row_reg, row_next;

    // init chain
    logic signed [OFF_W-1:0] prev_reg, prev_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       done_reg, done_next;
    logic       from_new_reg, from_new_next;
    logic [7:0] src_reg, src_next;

    logic accept;
    logic col_ok;

    // shared advance unit
    logic signed [OFF_W-1:0] adv_new;
    logic                    adv_moved;

    cmw_advance_unit u_adv (
        .off     (rd_data_reg),
        .off_new (adv_new),
        .moved   (adv_moved)
    );

    // init value: rnd mod 3 through reciprocal, then clamp to -15..0
    logic [15:0]             rnd_prod;
    logic [1:0]              rnd_mod3;
    logic signed [SW-1:0]    init_sum;
    logic signed [OFF_W-1:0] init_val;

    always_comb
    begin
        rnd_prod = 16'(random_value) * 16'd171;
        rnd_mod3 = 2'(random_value - 8'(rnd_prod[15:9]) * 8'd3);
        if (column == 8'd0)
        begin
            init_val = OFF_W'(-$signed({1'b0, random_value[3:0]}));
            init_sum = '0;
        end
        else
        begin
            init_sum = SW'(prev_reg) + SW'($signed({1'b0, rnd_mod3})) - ONE_X;
            if (init_sum > 0)
                init_val = '0;
            else if (init_sum < INIT_MIN_X)
                init_val = OFF_W'(INIT_MIN_X);
            else
                init_val = OFF_W'(init_sum);
        end
    end

    // lookup compare on the freshly read offset
    logic signed [OFF_W-1:0] off_eff;
    logic signed [LK_W-1:0]  row_s;
    logic signed [LK_W-1:0]  off_s;
    logic signed [LK_W-1:0]  diff_s;

    always_comb
    begin
        off_eff = (!look_ok_reg || rd_data_reg < 0) ? '0 : rd_data_reg;
        row_s   = signed'(LK_W'(row_reg));
        off_s   = LK_W'(off_eff);
        diff_s  = row_s - off_s;
    end

    assign col_ok   = 32'(column) < 32'(cmw_pkg::COLUMNS);
    assign in_stall = (state_reg != cmw_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        changed_next   = changed_reg;
        look_ok_next   = look_ok_reg;
        row_next       = row_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg && out_stall;
        done_next      = done_reg;
        from_new_next  = from_new_reg;
        src_next       = src_reg;
        rd_addr        = IDX_W'(column);
        mem_we         = 1'b0;
        wr_addr        = IDX_W'(column);
        wr_data        = init_val;

        case (state_reg)
            cmw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmw_pkg::func_t'(func))
                        cmw_pkg::FUNC_INIT:
                        begin
                            if (col_ok)
                            begin
                                mem_we    = 1'b1;
                                prev_next = init_val;
                            end
                            out_valid_next = 1'b1;
                            done_next      = 1'b0;
                            from_new_next  = 1'b0;
                            src_next       = '0;
                        end
                        cmw_pkg::FUNC_TICK:
                        begin
                            rd_idx_next  = '0;
                            pend_next    = 1'b0;
                            changed_next = 1'b0;
                            state_next   = cmw_pkg::ST_TICK;
                        end
                        cmw_pkg::FUNC_LOOKUP:
                        begin
                            // memory read of column is issued this cycle
                            look_ok_next = col_ok;
                            row_next     = row;
                            state_next   = cmw_pkg::ST_LOOK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            done_next      = 1'b0;
                            from_new_next  = 1'b0;
                            src_next       = '0;
                        end
                    endcase
                end
            end
            cmw_pkg::ST_TICK:
            begin
                rd_addr = rd_idx_reg[IDX_W-1:0];
                wr_addr = wr_idx_reg;
                wr_data = adv_new;
                if (pend_reg)
                begin
                    mem_we       = 1'b1;
                    changed_next = changed_reg || adv_moved;
                end
                if (rd_idx_reg != CNT_W'(cmw_pkg::COLUMNS))
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    wr_idx_next = rd_idx_reg[IDX_W-1:0];
                    pend_next   = 1'b1;
                end
                else
                begin
                    // last column written back this cycle
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    done_next      = !(changed_reg || (pend_reg && adv_moved));
                    from_new_next  = 1'b0;
                    src_next       = '0;
                    state_next     = cmw_pkg::ST_IDLE;
                end
            end
            cmw_pkg::ST_LOOK:
            begin
                out_valid_next = 1'b1;
                done_next      = 1'b0;
                if (row_s < off_s)
                begin
                    from_new_next = 1'b1;
                    src_next      = row_reg;
                end
                else
                begin
                    from_new_next = 1'b0;
                    src_next      = diff_s[7:0];
                end
                state_next = cmw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cmw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cmw_pkg::ST_IDLE;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            changed_reg   <= 1'b0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            changed_reg   <= changed_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg   <= wr_idx_next;
        look_ok_reg  <= look_ok_next;
        row_reg      <= row_next;
        done_reg     <= done_next;
        from_new_reg <= from_new_next;
        src_reg      <= src_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign done_res   = done_reg;
    assign from_new   = from_new_reg;
    assign source_row = src_reg;

endmodule

// File: dv/cmw_wipe_checker.sv
module cmw_wipe_checker
    import cmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] random_value,
    input  logic [7:0] column,
    input  logic [7:0] row,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       done_res,
    input  logic       from_new,
    input  logic [7:0] source_row,
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        logic       done;
        logic       new_screen;
        logic [7:0] src_row;
    } wipe_answer_t;

    // melt state mirrored from the item stream
    logic signed [OFF_W-1:0] melt_offset [COLUMNS];
    logic signed [OFF_W-1:0] chain_offset;
    wipe_answer_t            wanted_answers [$];

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        chain_offset = '0;
        for (int i = 0; i < COLUMNS; i++)
            melt_offset[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // one frame of the wipe, 1 when every column has already landed
    function automatic logic advance_melt();
        int   off;
        int   step;
        logic moved;
        moved = 1'b0;
        for (int i = 0; i < COLUMNS; i++)
        begin
            off = int'(melt_offset[i]);
            if (off < 0)
            begin
                melt_offset[i] = OFF_W'(off + 1);
                moved = 1'b1;
            end
            else if (off < ROWS)
            begin
                step = (off < FAST_LIMIT) ? off + 1 : SLOW_STEP;
                if (off + step >= ROWS)
                    step = ROWS - off;
                melt_offset[i] = OFF_W'(off + step);
                moved = 1'b1;
            end
        end
        return !moved;
    endfunction

    function automatic wipe_answer_t predict_answer(input logic [1:0] f,
                                                    input logic [7:0] rnd,
                                                    input logic [7:0] col,
                                                    input logic [7:0] rw);
        wipe_answer_t ans;
        int           v;
        int           off;
        ans = '0;
        case (f)
            FUNC_INIT:
            begin
                if (col < COLUMNS)
                begin
                    if (col == 0)
                        v = -(int'(rnd) % 16);
                    else
                    begin
                        v = int'(chain_offset) + int'(rnd) % 3 - 1;
                        if (v > 0)
                            v = 0;
                        else if (v < INIT_MIN)
                            v = INIT_MIN;
                    end
                    melt_offset[col] = OFF_W'(v);
                    chain_offset     = OFF_W'(v);
                end
            end
            FUNC_TICK:
                ans.done = advance_melt();
            FUNC_LOOKUP:
            begin
                off = (col < COLUMNS) ? int'(melt_offset[col]) : 0;
                if (off < 0)
                    off = 0;
                if (int'(rw) < off)
                begin
                    ans.new_screen = 1'b1;
                    ans.src_row    = rw;
                end
                else
                    ans.src_row = 8'(int'(rw) - off);
            end
            default:
                ans = '0;
        endcase
        return ans;
    endfunction

    always @(posedge clk)
    begin : watch
        wipe_answer_t want;
        if (rst_n)
        begin
            // a result is never seen at the edge that accepts its item, so check first
            if (out_valid && !out_stall)
            begin
                if (wanted_answers.size() == 0)
                    report_mismatch("result with no item waiting");
                else
                begin
                    want = wanted_answers.pop_front();
                    if (done_res !== want.done)
                        report_mismatch($sformatf("done_res %b, wanted %b",
                                                  done_res, want.done));
                    if (from_new !== want.new_screen)
                        report_mismatch($sformatf("from_new %b, wanted %b",
                                                  from_new, want.new_screen));
                    if (source_row !== want.src_row)
                        report_mismatch($sformatf("source_row %0d, wanted %0d",
                                                  source_row, want.src_row));
                end
            end
            if (in_valid && !in_stall)
                wanted_answers.push_back(predict_answer(func, random_value,
                                                        column, row));
            pending <= wanted_answers.size();
        end
    end

endmodule

// File: dv/column_melt_wipe_engine_unit_test.sv
module column_melt_wipe_engine_unit_test;
    import cmw_pkg::*;

    // func code the block leaves unused
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // stop making random items once this many have gone in
    localparam int ITEM_TARGET = 1500;
    // cycles with no handshake on either side before giving up;
    // a tick alone keeps the input busy while it walks every column
    localparam int STALL_LIMIT = 4000;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [1:0] func         = FUNC_INIT;
    logic [7:0] random_value = '0;
    logic [7:0] column       = '0;
    logic [7:0] row          = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       done_res;
    logic       from_new;
    logic [7:0] source_row;

    int   mismatches;
    int   pending;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    // high while both sides run without gaps
    logic calm        = 1'b0;

    always #1 clk = ~clk;

    column_melt_wipe_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .random_value (random_value),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .done_res     (done_res),
        .from_new     (from_new),
        .source_row   (source_row)
    );

    cmw_wipe_checker wipe_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .random_value (random_value),
        .column       (column),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .done_res     (done_res),
        .from_new     (from_new),
        .source_row   (source_row),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // receiver backs off now and then, never during a calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 14);

    // no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // present one item and hold it until the block takes it
    task automatic send_item(input logic [1:0] f, input logic [7:0] rnd,
                             input logic [7:0] col, input logic [7:0] rw);
        // random gap before the item, valid low meanwhile
        if (!calm && ($urandom_range(99) < 14))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        random_value <= rnd;
        column       <= col;
        row          <= rw;
        // taken at the first edge that sees stall low
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    initial
    begin
        int         ep;
        int         n;
        int         len;
        logic [7:0] rb;
        logic [7:0] pick_col;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // init past the last column, both extremes of the byte
        send_item(FUNC_INIT, 8'hff, 8'(COLUMNS), 8'h00);
        send_item(FUNC_INIT, 8'h00, 8'hff, 8'hff);
        // lookups past the last column read no offset
        send_item(FUNC_LOOKUP, 8'h00, 8'(COLUMNS), 8'h00);
        send_item(FUNC_LOOKUP, 8'hff, 8'hff, 8'hff);
        // unused func with every payload bit set
        send_item(FUNC_UNUSED, 8'hff, 8'hff, 8'hff);
        // out of order init right after reset builds on a zero chain, clamps at top
        send_item(FUNC_INIT, 8'd2, 8'd7, 8'd0);
        send_item(FUNC_LOOKUP, 8'd0, 8'd7, 8'd0);
        // restart at column 0 with the deepest start
        send_item(FUNC_INIT, 8'hff, 8'd0, 8'd0);
        // out of order init that clamps at the bottom
        send_item(FUNC_INIT, 8'h00, 8'd3, 8'd0);
        // negative offset reads as zero
        send_item(FUNC_LOOKUP, 8'd0, 8'd3, 8'(ROWS - 1));

        // full sweep so every column offset is defined from here on
        for (int c = 0; c < COLUMNS; c++)
            send_item(FUNC_INIT, (c == 0) ? 8'h00 : 8'($urandom_range(255)),
                      8'(c), 8'($urandom_range(255)));

        // a few ticks, then lookups at the corners
        repeat (6) send_item(FUNC_TICK, 8'($urandom_range(255)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
        send_item(FUNC_LOOKUP, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_LOOKUP, 8'd0, 8'(COLUMNS - 1), 8'(ROWS - 1));
        send_item(FUNC_LOOKUP, 8'd0, 8'd0, 8'hff);

        // --- random episodes: a re-init sweep then a melt run to completion ---
        ep = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // second episode runs without any gaps on either side
            calm = (ep == 1);
            len  = $urandom_range(1) ? COLUMNS : $urandom_range(COLUMNS, 1);
            for (int j = 0; j < len; j++)
            begin
                n  = $urandom_range(99);
                rb = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                              : 8'($urandom_range(255));
                if (n < 3)
                    send_item(FUNC_UNUSED, rb, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                else if (n < 6)
                    // init past the last column, ignored
                    send_item(FUNC_INIT, rb, 8'($urandom_range(255, COLUMNS)),
                              8'($urandom_range(255)));
                else if (n < 9)
                    // init out of order, chains from the last one written
                    send_item(FUNC_INIT, rb, 8'($urandom_range(COLUMNS - 1, 1)),
                              8'($urandom_range(255)));
                else if (n < 12)
                    send_item(FUNC_LOOKUP, rb, 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                else
                    send_item(FUNC_INIT, rb, 8'(j), 8'($urandom_range(255)));
            end
            // enough ticks to land every column and then report done
            repeat ($urandom_range(52, 46))
            begin
                send_item(FUNC_TICK, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 8'($urandom_range(255)));
                repeat ($urandom_range(6))
                begin
                    pick_col = ($urandom_range(99) < 85)
                               ? 8'($urandom_range(COLUMNS - 1))
                               : 8'($urandom_range(255, COLUMNS));
                    send_item(FUNC_LOOKUP, 8'($urandom_range(255)), pick_col,
                              8'($urandom_range(255)));
                end
            end
            ep++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain outstanding results, then a short settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
